// ===== rtl/core/irtx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irtx_pkg
// Shared types and constants for the infrared frame transmitter.
// ----------------------------------------------------------------------------
package irtx_pkg;

  // Frame layout
  localparam int FRAME_BITS = 32;
  localparam int BIT_CNT_W  = $clog2(FRAME_BITS);
  localparam int CODE_W     = 8;
  localparam int CARRIER_W  = 8;

  // Reset values of the configuration registers
  localparam logic [CARRIER_W-1:0] CARRIER_PERIOD_RST  = 8'd26;
  localparam logic [CARRIER_W-1:0] CARRIER_ON_TIME_RST = 8'd9;
  localparam int LEADER_MARK_RST  = 9000;
  localparam int LEADER_SPACE_RST = 4500;
  localparam int BIT_MARK_RST     = 560;
  localparam int ONE_SPACE_RST    = 1680;
  localparam int ZERO_SPACE_RST   = 560;
  localparam int STOP_MARK_RST    = 560;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_CARRIER_PERIOD    = 3'd0,
    REG_CARRIER_ON_TIME   = 3'd1,
    REG_LEADER_MARK_TIME  = 3'd2,
    REG_LEADER_SPACE_TIME = 3'd3,
    REG_BIT_MARK_TIME     = 3'd4,
    REG_ONE_SPACE_TIME    = 3'd5,
    REG_ZERO_SPACE_TIME   = 3'd6,
    REG_STOP_MARK_TIME    = 3'd7
  } cfg_idx_e;

  // Input item codes
  typedef enum logic {
    FUNC_TICK  = 1'b0,
    FUNC_START = 1'b1
  } func_e;

  // Frame segments, one-hot
  typedef enum logic [5:0] {
    SEG_IDLE       = 6'b000001,
    SEG_LEAD_MARK  = 6'b000010,
    SEG_LEAD_SPACE = 6'b000100,
    SEG_BIT_MARK   = 6'b001000,
    SEG_BIT_SPACE  = 6'b010000,
    SEG_STOP_MARK  = 6'b100000
  } seg_e;

  typedef struct packed {
    logic [CARRIER_W-1:0] period;
    logic [CARRIER_W-1:0] on_time;
  } carrier_cfg_t;

  typedef struct packed {
    logic led_pin;
    logic busy_res;
    logic frame_done;
  } result_t;

endpackage

// ===== rtl/core/irtx_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irtx_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface irtx_in_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [irtx_pkg::CODE_W-1:0] system_code;
  logic [irtx_pkg::CODE_W-1:0] key_code;

  modport source (output valid, output func, output system_code, output key_code,
                  input ready);
  modport sink   (input valid, input func, input system_code, input key_code,
                  output ready);
endinterface

interface irtx_out_if;
  logic valid;
  logic ready;
  logic led_pin;
  logic busy_res;
  logic frame_done;

  modport source (output valid, output led_pin, output busy_res, output frame_done,
                  input ready);
  modport sink   (input valid, input led_pin, input busy_res, input frame_done,
                  output ready);
endinterface

// ===== rtl/core/irtx_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irtx_cfg_regs
// Configuration register bank: carrier settings and segment durations.
// ----------------------------------------------------------------------------
module irtx_cfg_regs #(
  parameter int TimeWidth = 14,
  parameter int CfgWidth  = 14
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  irtx_pkg::cfg_idx_e       cfg_idx_i,
  input  logic [CfgWidth-1:0]      cfg_wdata_i,
  output irtx_pkg::carrier_cfg_t   carrier_o,
  output logic [TimeWidth-1:0]     leader_mark_o,
  output logic [TimeWidth-1:0]     leader_space_o,
  output logic [TimeWidth-1:0]     bit_mark_o,
  output logic [TimeWidth-1:0]     one_space_o,
  output logic [TimeWidth-1:0]     zero_space_o,
  output logic [TimeWidth-1:0]     stop_mark_o
);
  import irtx_pkg::*;

  carrier_cfg_t         carrier_q;
  logic [TimeWidth-1:0] leader_mark_q, leader_space_q, bit_mark_q;
  logic [TimeWidth-1:0] one_space_q, zero_space_q, stop_mark_q;
  logic [CARRIER_W-1:0] wdata8;
  logic [TimeWidth-1:0] wdata_t;

  assign wdata8  = cfg_wdata_i[CARRIER_W-1:0];
  assign wdata_t = cfg_wdata_i[TimeWidth-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carrier_q.period  <= CARRIER_PERIOD_RST;
      carrier_q.on_time <= CARRIER_ON_TIME_RST;
      leader_mark_q     <= TimeWidth'(LEADER_MARK_RST);
      leader_space_q    <= TimeWidth'(LEADER_SPACE_RST);
      bit_mark_q        <= TimeWidth'(BIT_MARK_RST);
      one_space_q       <= TimeWidth'(ONE_SPACE_RST);
      zero_space_q      <= TimeWidth'(ZERO_SPACE_RST);
      stop_mark_q       <= TimeWidth'(STOP_MARK_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CARRIER_PERIOD:    carrier_q.period  <= wdata8;
        REG_CARRIER_ON_TIME:   carrier_q.on_time <= wdata8;
        REG_LEADER_MARK_TIME:  leader_mark_q     <= wdata_t;
        REG_LEADER_SPACE_TIME: leader_space_q    <= wdata_t;
        REG_BIT_MARK_TIME:     bit_mark_q        <= wdata_t;
        REG_ONE_SPACE_TIME:    one_space_q       <= wdata_t;
        REG_ZERO_SPACE_TIME:   zero_space_q      <= wdata_t;
        REG_STOP_MARK_TIME:    stop_mark_q       <= wdata_t;
        default: ;
      endcase
    end
  end

  assign carrier_o      = carrier_q;
  assign leader_mark_o  = leader_mark_q;
  assign leader_space_o = leader_space_q;
  assign bit_mark_o     = bit_mark_q;
  assign one_space_o    = one_space_q;
  assign zero_space_o   = zero_space_q;
  assign stop_mark_o    = stop_mark_q;

endmodule

// ===== rtl/core/irtx_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irtx_sequencer
// Frame segment sequencer, duration timer and carrier gate.
// ----------------------------------------------------------------------------
module irtx_sequencer #(
  parameter int TimeWidth = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          func_i,
  input  logic [irtx_pkg::CODE_W-1:0]   system_code_i,
  input  logic [irtx_pkg::CODE_W-1:0]   key_code_i,
  input  irtx_pkg::carrier_cfg_t        carrier_i,
  input  logic [TimeWidth-1:0]          leader_mark_i,
  input  logic [TimeWidth-1:0]          leader_space_i,
  input  logic [TimeWidth-1:0]          bit_mark_i,
  input  logic [TimeWidth-1:0]          one_space_i,
  input  logic [TimeWidth-1:0]          zero_space_i,
  input  logic [TimeWidth-1:0]          stop_mark_i,
  output irtx_pkg::result_t             result_o
);
  import irtx_pkg::*;

  seg_e                   seg_q, seg_d;
  logic [TimeWidth-1:0]   time_q, time_d;
  logic [BIT_CNT_W-1:0]   bits_q, bits_d;
  logic [CARRIER_W-1:0]   phase_q, phase_d;
  logic [FRAME_BITS-1:0]  word_q, word_d;
  logic [CARRIER_W:0]     phase_inc;
  logic                   is_mark;
  result_t                res;

  // A zero duration counts as one tick
  function automatic logic [TimeWidth-1:0] dur(input logic [TimeWidth-1:0] d);
    return (d == '0) ? TimeWidth'(1) : d;
  endfunction

  assign phase_inc = {1'b0, phase_q} + (CARRIER_W+1)'(1);
  assign is_mark   = (seg_q == SEG_LEAD_MARK) || (seg_q == SEG_BIT_MARK) ||
                     (seg_q == SEG_STOP_MARK);

  always_comb begin
    seg_d   = seg_q;
    time_d  = time_q;
    bits_d  = bits_q;
    phase_d = phase_q;
    word_d  = word_q;
    res     = '{led_pin: 1'b1, busy_res: 1'b0, frame_done: 1'b0};

    if (func_i == FUNC_START) begin
      if (seg_q == SEG_IDLE) begin
        word_d  = {~key_code_i, key_code_i, ~system_code_i, system_code_i};
        bits_d  = '0;
        seg_d   = SEG_LEAD_MARK;
        time_d  = dur(leader_mark_i);
        phase_d = '0;
      end
      res.busy_res = 1'b1;
    end else if (seg_q != SEG_IDLE) begin
      res.busy_res = 1'b1;
      if (is_mark) begin
        res.led_pin = !(phase_q < carrier_i.on_time);
        phase_d = (phase_inc >= {1'b0, carrier_i.period}) ? '0 : phase_inc[CARRIER_W-1:0];
      end
      if (time_q > TimeWidth'(1)) begin
        time_d = time_q - TimeWidth'(1);
      end else begin
        // segment ends: every new segment restarts the carrier
        phase_d = '0;
        unique case (seg_q)
          SEG_LEAD_MARK: begin
            seg_d  = SEG_LEAD_SPACE;
            time_d = dur(leader_space_i);
          end
          SEG_LEAD_SPACE: begin
            seg_d  = SEG_BIT_MARK;
            time_d = dur(bit_mark_i);
          end
          SEG_BIT_MARK: begin
            seg_d  = SEG_BIT_SPACE;
            time_d = word_q[bits_q] ? dur(one_space_i) : dur(zero_space_i);
          end
          SEG_BIT_SPACE: begin
            bits_d = bits_q + BIT_CNT_W'(1);
            if (bits_q == BIT_CNT_W'(FRAME_BITS - 1)) begin
              seg_d  = SEG_STOP_MARK;
              time_d = dur(stop_mark_i);
            end else begin
              seg_d  = SEG_BIT_MARK;
              time_d = dur(bit_mark_i);
            end
          end
          SEG_STOP_MARK: begin
            seg_d          = SEG_IDLE;
            time_d         = '0;
            res.frame_done = 1'b1;
          end
          default: begin
            seg_d  = SEG_IDLE;
            time_d = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q   <= SEG_IDLE;
      time_q  <= '0;
      bits_q  <= '0;
      phase_q <= '0;
      word_q  <= '0;
    end else if (accept_i) begin
      seg_q   <= seg_d;
      time_q  <= time_d;
      bits_q  <= bits_d;
      phase_q <= phase_d;
      word_q  <= word_d;
    end
  end

  assign result_o = res;

endmodule

// ===== rtl/core/ir_frame_transmitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_frame_transmitter
// NEC-style infrared remote frame sender with carrier gating.
// ----------------------------------------------------------------------------
// One beat in, one beat out: every accepted item (start or one-microsecond
// tick) yields exactly one result in the next cycle from the output register, and
// a new item is taken every cycle while that register is empty or being
// drained. The throughput of one item per cycle is set by the single
// sequencer update between the input handshake and the result register.
// A start loads {~key, key, ~system, system}, sent LSB first after a leader
// mark and space, and closed by a stop mark; a start during a frame is
// ignored. Configuration may only be written while no frame is in flight.
module ir_frame_transmitter #(
  parameter int TimeWidth = 14
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  irtx_in_if.sink                  in_i,
  irtx_out_if.source               out_o,
  input  logic                     cfg_we_i,
  input  irtx_pkg::cfg_idx_e       cfg_idx_i,
  input  logic [((TimeWidth > irtx_pkg::CARRIER_W) ? TimeWidth :
                 irtx_pkg::CARRIER_W)-1:0] cfg_wdata_i
);
  import irtx_pkg::*;

  localparam int CfgWidth = (TimeWidth > CARRIER_W) ? TimeWidth : CARRIER_W;

  carrier_cfg_t         carrier;
  logic [TimeWidth-1:0] leader_mark, leader_space, bit_mark;
  logic [TimeWidth-1:0] one_space, zero_space, stop_mark;
  logic                 accept;
  result_t              res_d, res_q;
  logic                 out_valid_q, out_valid_d;

  irtx_cfg_regs #(
    .TimeWidth (TimeWidth),
    .CfgWidth  (CfgWidth)
  ) u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .carrier_o      (carrier),
    .leader_mark_o  (leader_mark),
    .leader_space_o (leader_space),
    .bit_mark_o     (bit_mark),
    .one_space_o    (one_space),
    .zero_space_o   (zero_space),
    .stop_mark_o    (stop_mark)
  );

  irtx_sequencer #(
    .TimeWidth (TimeWidth)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .func_i         (in_i.func),
    .system_code_i  (in_i.system_code),
    .key_code_i     (in_i.key_code),
    .carrier_i      (carrier),
    .leader_mark_i  (leader_mark),
    .leader_space_i (leader_space),
    .bit_mark_i     (bit_mark),
    .one_space_i    (one_space),
    .zero_space_i   (zero_space),
    .stop_mark_i    (stop_mark),
    .result_o       (res_d)
  );

  // Output register frees up in the same cycle its beat is taken
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.led_pin    = res_q.led_pin;
  assign out_o.busy_res   = res_q.busy_res;
  assign out_o.frame_done = res_q.frame_done;

  // Every accepted beat leaves a result waiting in the next cycle
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_o.valid)
    else $error("accepted beat produced no result");

  // The frame end is only flagged inside a frame
  a_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.frame_done) |-> out_o.busy_res)
    else $error("frame_done outside a frame");

  // LED is never lit outside a frame
  a_led_dark_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.led_pin) |-> out_o.busy_res)
    else $error("LED lit while idle");

endmodule
